### rtl/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg: shared types and constants of the tempo ratio classifier
// Item, job and result structs, relation kind codes, default bounds.
// ----------------------------------------------------------------------------
`default_nettype none

package trc_pkg;

	localparam int DEF_MAX_DENOMINATOR = 16;
	localparam int DEF_MAX_NUMERATOR   = 32;
	localparam int DEF_MAX_OCTAVE      = 5;
	localparam int JOB_QUEUE_DEPTH     = 2;
	localparam int RESULT_QUEUE_DEPTH  = 2;

	localparam logic [15:0] TOLERANCE_FLOOR = 16'd786;
	localparam logic [23:0] RATE_MAX        = 24'hFFFFFF;

	localparam logic [1:0] KIND_UNRESOLVED = 2'd0;
	localparam logic [1:0] KIND_HARMONIC   = 2'd1;
	localparam logic [1:0] KIND_RATIONAL   = 2'd2;

	typedef struct packed {
		logic [15:0] candidate_rate;
		logic [15:0] reference_rate;
		logic [15:0] candidate_score;
		logic [15:0] window_reliability;
	} trc_item_t;

	typedef struct packed {
		trc_item_t   item;
		logic [15:0] tol;
		logic        fault;
	} trc_job_t;

	typedef struct packed {
		logic [1:0]  relation_kind;
		logic [5:0]  ratio_numerator;
		logic [5:0]  ratio_denominator;
		logic [23:0] relative_rate;
		logic [15:0] confidence_out;
		logic        divide_fault;
	} trc_result_t;

endpackage

`default_nettype wire

### rtl/trc_fifo.sv
// ----------------------------------------------------------------------------
// trc_fifo: small register queue
// Holds requests between the front and back parts, and finished results.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire T     wr_data,
	output logic      full,
	input  wire logic rd_en,
	output T          rd_data,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/trc_front.sv
// ----------------------------------------------------------------------------
// trc_front: request intake
// Holds the tolerance register, flags a zero reference and forms the job.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_front import trc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire trc_item_t   item,
	output trc_job_t         job
);

	logic [15:0] tol_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOLERANCE_FLOOR;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	always_comb begin
		job.item  = item;
		job.tol   = (tol_q < TOLERANCE_FLOOR) ? TOLERANCE_FLOOR : tol_q;
		job.fault = (item.reference_rate == 16'd0);
	end

endmodule

`default_nettype wire

### rtl/trc_back.sv
// ----------------------------------------------------------------------------
// trc_back: relation engine
// Divides, finds the nearest octave, scans denominators and builds results.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_back import trc_pkg::*; #(
	parameter int MAX_DENOMINATOR = DEF_MAX_DENOMINATOR,
	parameter int MAX_NUMERATOR   = DEF_MAX_NUMERATOR,
	parameter int MAX_OCTAVE      = DEF_MAX_OCTAVE
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     job_avail,
	output logic          job_pop,
	input  wire trc_job_t job,
	output logic          res_push,
	input  wire logic     res_full,
	output trc_result_t   res
);

	localparam int DW  = $clog2(MAX_DENOMINATOR + 1);
	localparam int NW0 = $clog2(MAX_NUMERATOR + 1);
	localparam int NW  = (NW0 > MAX_OCTAVE + 1) ? NW0 : MAX_OCTAVE + 1;
	localparam int BW  = (NW > DW) ? NW : DW;
	localparam int EW  = 16 + BW;
	localparam int QW  = 16 + DW;
	localparam int OW  = 32 + 4 * MAX_OCTAVE + 3;
	localparam int NOCT = 2 * MAX_OCTAVE + 1;
	localparam int XW  = $clog2(MAX_OCTAVE + 1);
	localparam int VW  = $clog2(NOCT);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIV   = 4'd1;
	localparam logic [3:0] ST_POST  = 4'd2;
	localparam logic [3:0] ST_HARM  = 4'd3;
	localparam logic [3:0] ST_RAT   = 4'd4;
	localparam logic [3:0] ST_DRAIN = 4'd5;
	localparam logic [3:0] ST_TEST  = 4'd6;
	localparam logic [3:0] ST_OUT   = 4'd7;

	logic [3:0]  state_q;
	logic [15:0] c_q, r_q, s_q, w_q, tol_q;
	logic        fault_q;

	logic [16:0] drem_q;
	logic [31:0] dquo_q;
	logic [3:0]  dcnt_q;
	logic [16:0] drem_n;
	logic [31:0] dquo_n;

	logic [31:0] c2_q, r2_q;
	logic [22:0] cbase;
	logic [38:0] conf_s1;
	logic [22:0] conf_s2;
	logic [22:0] conf_y_s3;
	logic        conf_sat_s3;
	logic [16:0] conf_s3;
	logic [38:0] conf_mul;
	logic [21:0] conf_chk;
	logic [15:0] conf_q;

	logic [23:0] rel_q;
	logic [15:0] qint_q, crem_q;
	logic [31:0] qr_prod;

	logic          hfound;
	logic [VW-1:0] hexp;
	logic [XW-1:0] hkn_q, hkd_q;
	logic          hfound_q;
	logic [OW-1:0] oct_mid, oct_lo, oct_hi;

	logic [QW-1:0] q_q;
	logic [15:0]   qrem_q;
	logic [DW-1:0] d_q;
	logic          phase_q;
	logic [16:0]   qrem_sum;
	logic [QW:0]   qx;
	logic [BW-1:0] nsel;
	logic [EW-1:0] a_cd, a_rn;

	logic [EW-1:0] err_s1, ref_s1;
	logic [BW-1:0] n_s1, d_s1;
	logic          v_s1;

	logic [BW-1:0]   bn_q, bd_q;
	logic [EW-1:0]   berr_q, bref_q;
	logic            have_q;
	logic [2*EW-1:0] lhs, rhs;
	logic            take;

	logic            hmode_q;
	logic [EW+15:0]  tol_prod;
	logic            pass;
	logic [1:0]      kind_q;

	logic [EW-1:0]   h_cd, h_rn;
	logic [BW+5:0]   nx, dx;

	// two restoring divide steps per cycle
	always_comb begin
		logic [16:0] rm;
		logic [31:0] qu;
		rm = drem_q;
		qu = dquo_q;
		for (int i = 0; i < 2; i++) begin
			rm = {rm[15:0], qu[31]};
			qu = {qu[30:0], 1'b0};
			if (rm >= {1'b0, r_q}) begin
				rm    = rm - {1'b0, r_q};
				qu[0] = 1'b1;
			end
		end
		drem_n = rm;
		dquo_n = qu;
	end

	assign cbase    = 23'd2293760 + ({7'd0, w_q} << 6) + {7'd0, w_q};
	assign conf_mul = 39'(conf_s2[20:0]) * 39'd167773;
	assign conf_chk = 22'(conf_s3) * 22'd25;

	// nearest octave in the log domain
	always_comb begin
		oct_mid = OW'(c2_q) << (2 * MAX_OCTAVE + 1);
		hfound  = 1'b0;
		hexp    = '0;
		oct_lo  = '0;
		oct_hi  = '0;
		for (int e = NOCT - 1; e >= 0; e--) begin
			oct_lo = OW'(r2_q) << (2 * e);
			oct_hi = OW'(r2_q) << (2 * e + 2);
			if (oct_lo <= oct_mid && oct_mid < oct_hi) begin
				hfound = 1'b1;
				hexp   = VW'(e);
			end
		end
	end

	assign qr_prod = r_q * dquo_q[31:16];

	assign h_cd = EW'(c_q) << hkd_q;
	assign h_rn = EW'(r_q) << hkn_q;

	// candidate numerators floor and ceil of c*d/r, clamped
	assign qrem_sum = {1'b0, qrem_q} + {1'b0, crem_q};
	always_comb begin
		qx = phase_q ? {1'b0, q_q} + 1'b1 : {1'b0, q_q};
		if (qx == '0) begin
			nsel = BW'(1);
		end else if (qx > (QW+1)'(MAX_NUMERATOR)) begin
			nsel = BW'(MAX_NUMERATOR);
		end else begin
			nsel = qx[BW-1:0];
		end
	end
	assign a_cd = EW'(c_q) * EW'(d_q);
	assign a_rn = EW'(r_q) * EW'(nsel);

	assign lhs  = (2*EW)'(err_s1) * (2*EW)'(bref_q);
	assign rhs  = (2*EW)'(berr_q) * (2*EW)'(ref_s1);
	assign take = !have_q || (lhs < rhs) ||
		(lhs == rhs && ({1'b0, n_s1} + {1'b0, d_s1}) < ({1'b0, bn_q} + {1'b0, bd_q}));

	assign tol_prod = (EW+16)'(tol_q) * (EW+16)'(bref_q);
	assign pass     = {berr_q, 16'd0} <= tol_prod;

	always_ff @(posedge clk) begin
		c2_q        <= c_q * c_q;
		r2_q        <= r_q * r_q;
		conf_s1     <= s_q * cbase;
		conf_s2     <= conf_s1[38:16];
		conf_y_s3   <= conf_s2;
		conf_sat_s3 <= (conf_s2 >= 23'd1638400);
		conf_s3     <= conf_mul[38:22];
		if (conf_sat_s3) begin
			conf_q <= 16'hFFFF;
		end else if (conf_chk > {1'b0, conf_y_s3[20:0]}) begin
			conf_q <= 16'(conf_s3 - 1'b1);
		end else begin
			conf_q <= conf_s3[15:0];
		end
		err_s1 <= a_rn > a_cd ? a_rn - a_cd : a_cd - a_rn;
		ref_s1 <= a_rn;
		n_s1   <= nsel;
		d_s1   <= BW'(d_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			v_s1     <= 1'b0;
			have_q   <= 1'b0;
			hmode_q  <= 1'b0;
			kind_q   <= KIND_UNRESOLVED;
			phase_q  <= 1'b0;
			dcnt_q   <= '0;
			d_q      <= '0;
			hfound_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RAT);
			if (v_s1 && take) begin
				have_q <= 1'b1;
				bn_q   <= n_s1;
				bd_q   <= d_s1;
				berr_q <= err_s1;
				bref_q <= ref_s1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_avail) begin
						c_q     <= job.item.candidate_rate;
						r_q     <= job.item.reference_rate;
						s_q     <= job.item.candidate_score;
						w_q     <= job.item.window_reliability;
						tol_q   <= job.tol;
						fault_q <= job.fault;
						drem_q  <= '0;
						dquo_q  <= {job.item.candidate_rate, 16'd0};
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					drem_q <= drem_n;
					dquo_q <= dquo_n;
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 4'd15) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					rel_q    <= (fault_q || dquo_q[31:24] != 8'd0) ? RATE_MAX : dquo_q[23:0];
					qint_q   <= dquo_q[31:16];
					crem_q   <= 16'(c_q - qr_prod[15:0]);
					hfound_q <= hfound && (c_q != 16'd0);
					hkn_q    <= (hexp >= VW'(MAX_OCTAVE)) ? XW'(hexp - VW'(MAX_OCTAVE)) : '0;
					hkd_q    <= (hexp < VW'(MAX_OCTAVE)) ? XW'(VW'(MAX_OCTAVE) - hexp) : '0;
					kind_q   <= KIND_UNRESOLVED;
					if (fault_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_HARM;
					end
				end
				ST_HARM: begin
					if (hfound_q) begin
						bn_q    <= BW'(1) << hkn_q;
						bd_q    <= BW'(1) << hkd_q;
						berr_q  <= h_rn > h_cd ? h_rn - h_cd : h_cd - h_rn;
						bref_q  <= h_rn;
						hmode_q <= 1'b1;
						state_q <= ST_TEST;
					end else begin
						q_q     <= QW'(qint_q);
						qrem_q  <= crem_q;
						d_q     <= DW'(1);
						phase_q <= 1'b0;
						have_q  <= 1'b0;
						hmode_q <= 1'b0;
						state_q <= ST_RAT;
					end
				end
				ST_RAT: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						d_q <= d_q + 1'b1;
						if (qrem_sum >= {1'b0, r_q}) begin
							qrem_q <= 16'(qrem_sum - {1'b0, r_q});
							q_q    <= q_q + QW'(qint_q) + 1'b1;
						end else begin
							qrem_q <= qrem_sum[15:0];
							q_q    <= q_q + QW'(qint_q);
						end
						if (d_q == DW'(MAX_DENOMINATOR)) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (hmode_q) begin
						if (pass) begin
							kind_q  <= KIND_HARMONIC;
							state_q <= ST_OUT;
						end else begin
							q_q     <= QW'(qint_q);
							qrem_q  <= crem_q;
							d_q     <= DW'(1);
							phase_q <= 1'b0;
							have_q  <= 1'b0;
							hmode_q <= 1'b0;
							state_q <= ST_RAT;
						end
					end else begin
						kind_q  <= (pass && have_q) ? KIND_RATIONAL : KIND_UNRESOLVED;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign job_pop  = (state_q == ST_IDLE) && job_avail;
	assign res_push = (state_q == ST_OUT);

	assign nx = {6'd0, bn_q};
	assign dx = {6'd0, bd_q};

	always_comb begin
		res.relation_kind     = kind_q;
		res.ratio_numerator   = (kind_q == KIND_UNRESOLVED) ? 6'd0 : nx[5:0];
		res.ratio_denominator = (kind_q == KIND_UNRESOLVED) ? 6'd0 : dx[5:0];
		res.relative_rate     = rel_q;
		res.confidence_out    = conf_q;
		res.divide_fault      = fault_q;
	end

endmodule

`default_nettype wire

### rtl/tempo_ratio_classifier.sv
// ----------------------------------------------------------------------------
// tempo_ratio_classifier: relates a candidate tempo to a reference tempo
// Rate ratio, confidence and harmonic or rational classification.
// ----------------------------------------------------------------------------
// Requests enter through push/full: one is taken at an edge with push high and
// full low. A two-entry job queue lets new requests in while the engine works.
// Results leave through empty/pop from a two-entry result queue; the oldest
// result sits on the result port while empty is low.
// The engine takes a job, runs the radix-4 divider, then the octave check and,
// when no octave fits or the octave found misses the tolerance, a rational
// scan over every denominator up to MAX_DENOMINATOR. A zero reference skips
// both checks. The engine works on one job at a time.
// A stalled receiver fills the result queue, then the engine holds its result,
// then the job queue fills and full rises. Reset empties both queues and sets
// the tolerance register to 786. The configuration channel is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tempo_ratio_classifier import trc_pkg::*; #(
	parameter int MAX_DENOMINATOR = DEF_MAX_DENOMINATOR,
	parameter int MAX_NUMERATOR   = DEF_MAX_NUMERATOR,
	parameter int MAX_OCTAVE      = DEF_MAX_OCTAVE
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire trc_item_t   item,
	output logic             empty,
	input  wire logic        pop,
	output trc_result_t      result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	trc_job_t    front_job;
	trc_job_t    back_job;
	logic        job_full, job_empty, job_pop;
	trc_result_t back_res;
	logic        res_push, res_full;

	assign full = job_full;

	trc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.item      (item),
		.job       (front_job)
	);

	trc_fifo #(.T(trc_job_t), .DEPTH(JOB_QUEUE_DEPTH)) u_job_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_job),
		.full    (job_full),
		.rd_en   (job_pop),
		.rd_data (back_job),
		.empty   (job_empty)
	);

	trc_back #(
		.MAX_DENOMINATOR (MAX_DENOMINATOR),
		.MAX_NUMERATOR   (MAX_NUMERATOR),
		.MAX_OCTAVE      (MAX_OCTAVE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (!job_empty),
		.job_pop   (job_pop),
		.job       (back_job),
		.res_push  (res_push),
		.res_full  (res_full),
		.res       (back_res)
	);

	trc_fifo #(.T(trc_result_t), .DEPTH(RESULT_QUEUE_DEPTH)) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (back_res),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the tempo ratio classifier
// Sends directed and random tempo requests through the push/full port while
// the tolerance register steps through several settings. Each accepted
// request gets its expected result from a bit-exact predictor, or from a
// typed-in value for some of the directed rows. Results popped off the empty/pop port
// are compared field by field against those expectations, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import trc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_PHASES   = 5;
	localparam int PHASE_REQS = 270;
	localparam int DRAIN_WAIT = 100;

	typedef struct {
		trc_item_t   req;
		bit          typed;
		trc_result_t res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	trc_item_t   item = '0;
	logic        empty;
	logic        pop = 1'b0;
	trc_result_t result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	logic [15:0]  tol_reg = TOLERANCE_FLOOR;
	trc_result_t  pending_results[$];
	dir_row_t     dir_rows[$];
	int           n_errors = 0;
	bit           quiet = 1'b0;
	bit           hold_off = 1'b0;

	tempo_ratio_classifier i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic longint unsigned absdiff(longint unsigned a, longint unsigned b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic trc_result_t classify_tempo(trc_item_t it, logic [15:0] tol_in);
		longint unsigned c, r, s, w, tol, conf, rel, mid, lo, hi, hn, hd;
		longint unsigned bn, bd, berr, bref, err, rn, lhs, rhs;
		bit have, take;
		trc_result_t res;
		c = it.candidate_rate;
		r = it.reference_rate;
		s = it.candidate_score;
		w = it.window_reliability;
		tol = (tol_in < TOLERANCE_FLOOR) ? TOLERANCE_FLOOR : tol_in;
		res = '0;
		conf = (4 * s * (2293760 + 65 * w)) / 6553600;
		if (conf > 65535) conf = 65535;
		res.confidence_out = conf[15:0];
		if (r == 0) begin
			res.divide_fault = 1'b1;
			res.relative_rate = RATE_MAX;
			res.relation_kind = KIND_UNRESOLVED;
			return res;
		end
		rel = (c << 16) / r;
		if (rel > RATE_MAX) rel = RATE_MAX;
		res.relative_rate = rel[23:0];
		res.relation_kind = KIND_UNRESOLVED;
		if (c > 0) begin
			mid = (c * c) << (2 * DEF_MAX_OCTAVE + 1);
			for (int k = -DEF_MAX_OCTAVE; k <= DEF_MAX_OCTAVE; k++) begin
				lo = (r * r) << (2 * (k + DEF_MAX_OCTAVE));
				hi = (r * r) << (2 * (k + DEF_MAX_OCTAVE) + 2);
				if (lo <= mid && mid < hi) begin
					hn = (k >= 0) ? (64'd1 << k) : 1;
					hd = (k >= 0) ? 1 : (64'd1 << (-k));
					if (absdiff(c * hd, r * hn) * 65536 <= tol * r * hn) begin
						res.relation_kind = KIND_HARMONIC;
						res.ratio_numerator = hn[5:0];
						res.ratio_denominator = hd[5:0];
					end
					break;
				end
			end
		end
		if (res.relation_kind == KIND_UNRESOLVED) begin
			have = 1'b0;
			bn = 0; bd = 0; berr = 0; bref = 1;
			for (longint unsigned d = 1; d <= DEF_MAX_DENOMINATOR; d++) begin
				for (longint unsigned n = 1; n <= DEF_MAX_NUMERATOR; n++) begin
					err = absdiff(c * d, r * n);
					rn = r * n;
					if (!have) begin
						take = 1'b1;
					end else begin
						lhs = err * bref;
						rhs = berr * rn;
						take = (lhs < rhs) || (lhs == rhs && n + d < bn + bd);
					end
					if (take) begin
						have = 1'b1;
						bn = n; bd = d; berr = err; bref = rn;
					end
				end
			end
			if (have && absdiff(c * bd, r * bn) * 65536 <= tol * r * bn) begin
				res.relation_kind = KIND_RATIONAL;
				res.ratio_numerator = bn[5:0];
				res.ratio_denominator = bd[5:0];
			end
		end
		return res;
	endfunction

	function automatic dir_row_t make_row(logic [15:0] c, logic [15:0] r, logic [15:0] s,
			logic [15:0] w, bit typed, logic [1:0] kind, logic [5:0] n, logic [5:0] d,
			logic [23:0] rel, logic [15:0] conf, logic fault);
		dir_row_t row;
		row.req = '{c, r, s, w};
		row.typed = typed;
		row.res = '{kind, n, d, rel, conf, fault};
		return row;
	endfunction

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		$display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
		n_errors++;
	endtask

	task automatic send_request(trc_item_t it, bit typed, trc_result_t typed_res);
		while (!quiet && $urandom_range(99) < 16) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		pending_results.insert(pending_results.size(),
			typed ? typed_res : classify_tempo(it, tol_reg));
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tol_reg = value;
	endtask

	function automatic trc_item_t random_request();
		trc_item_t it;
		int unsigned n, d, rmax, sel;
		longint signed c;
		it.candidate_score = 16'($urandom_range(65535));
		it.window_reliability = 16'($urandom_range(65535));
		sel = $urandom_range(99);
		if (sel < 20) begin
			it.candidate_rate = 16'($urandom_range(65535));
			it.reference_rate = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(65535));
			return it;
		end
		if (sel < 55) begin
			n = 1 << $urandom_range(5);
			d = ($urandom_range(1)) ? 1 : n;
			if (d != 1) n = 1;
			if ($urandom_range(3) == 0) begin
				d = 1 << $urandom_range(5);
				n = 1;
			end
		end else begin
			n = $urandom_range(DEF_MAX_NUMERATOR, 1);
			d = $urandom_range(DEF_MAX_DENOMINATOR, 1);
		end
		rmax = (65535 * d) / n;
		if (rmax > 65535) rmax = 65535;
		if (rmax < 1) rmax = 1;
		it.reference_rate = 16'($urandom_range(rmax, 1));
		c = (longint'(it.reference_rate) * n) / d;
		case ($urandom_range(3))
			0: c = c;
			1: c = c + $signed($urandom_range(8)) - 4;
			2: c = c + (c * $signed($urandom_range(40)) - c * 20) / 1000;
			default: c = c + $signed($urandom_range(200)) - 100;
		endcase
		if (c < 0) c = 0;
		if (c > 65535) c = 65535;
		it.candidate_rate = c[15:0];
		return it;
	endfunction

	always @(posedge clk) begin
		trc_result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request waiting", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (result.relation_kind !== want.relation_kind)
					report_mismatch("relation_kind", result.relation_kind, want.relation_kind);
				if (result.ratio_numerator !== want.ratio_numerator)
					report_mismatch("ratio_numerator", result.ratio_numerator,
						want.ratio_numerator);
				if (result.ratio_denominator !== want.ratio_denominator)
					report_mismatch("ratio_denominator", result.ratio_denominator,
						want.ratio_denominator);
				if (result.relative_rate !== want.relative_rate)
					report_mismatch("relative_rate", result.relative_rate, want.relative_rate);
				if (result.confidence_out !== want.confidence_out)
					report_mismatch("confidence_out", result.confidence_out,
						want.confidence_out);
				if (result.divide_fault !== want.divide_fault)
					report_mismatch("divide_fault", result.divide_fault, want.divide_fault);
			end
		end
	end

	// receiver: random idling, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off) begin
				pop <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			pop <= quiet || ($urandom_range(99) >= 16);
		end
	end

	initial begin
		#20_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		trc_result_t none;
		logic [15:0] phase_tol[N_PHASES];
		none = '0;
		phase_tol = '{16'd0, 16'd65535, 16'd3000, 16'($urandom_range(65535)), 16'd786};

		// directed rows: typed where obvious, predictor otherwise
		dir_rows.insert(dir_rows.size(), make_row(64, 64, 0, 0, 1, KIND_HARMONIC, 1, 1,
			65536, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(100, 0, 16384, 65535, 1, KIND_UNRESOLVED,
			0, 0, RATE_MAX, 65535, 1));
		dir_rows.insert(dir_rows.size(), make_row(0, 64, 65535, 65535, 1, KIND_UNRESOLVED,
			0, 0, 0, 65535, 0));
		dir_rows.insert(dir_rows.size(), make_row(128, 64, 16384, 0, 1, KIND_HARMONIC, 2, 1,
			131072, 22937, 0));
		dir_rows.insert(dir_rows.size(), make_row(192, 128, 0, 0, 1, KIND_RATIONAL, 3, 2,
			98304, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(2048, 64, 0, 0, 1, KIND_HARMONIC, 32, 1,
			2097152, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(2, 64, 0, 0, 1, KIND_HARMONIC, 1, 32,
			2048, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(0, 0, 0, 0, 1, KIND_UNRESOLVED, 0, 0,
			RATE_MAX, 0, 1));
		dir_rows.insert(dir_rows.size(), make_row(65535, 1, 65535, 0, 0, KIND_UNRESOLVED,
			0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(65535, 65535, 65535, 65535, 0,
			KIND_UNRESOLVED, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(1, 65535, 1, 1, 0, KIND_UNRESOLVED,
			0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(4096, 64, 32768, 32768, 0, KIND_UNRESOLVED,
			0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(1, 64, 0, 0, 0, KIND_UNRESOLVED,
			0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(7872, 7680, 16384, 65535, 0,
			KIND_UNRESOLVED, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(10240, 7680, 12000, 40000, 0,
			KIND_UNRESOLVED, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(7700, 7680, 16384, 16384, 0,
			KIND_UNRESOLVED, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(5119, 7680, 50000, 100, 0,
			KIND_UNRESOLVED, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(21 * 640, 13 * 640, 16383, 65534, 0,
			KIND_UNRESOLVED, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(31 * 64, 16 * 64, 32767, 21845, 0,
			KIND_UNRESOLVED, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), make_row(43690, 21845, 43690, 21845, 0,
			KIND_UNRESOLVED, 0, 0, 0, 0, 0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
		wait_drained();

		for (int p = 0; p < N_PHASES; p++) begin
			write_tolerance(phase_tol[p]);
			for (int i = 0; i < PHASE_REQS; i++) begin
				quiet = (p == 2 && i >= 60 && i < 200);
				if (p == 0 && i == 30) hold_off = 1'b1;
				send_request(random_request(), 1'b0, none);
			end
			quiet = 1'b0;
			wait_drained();
		end

		if (n_errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
